FILE: design/qltu_pkg.sv
package qltu_pkg;

    // Default sizes of the table and of one stored Q value.
    localparam int MAX_COLS_DEF   = 16;
    localparam int MAX_ROWS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Field widths fixed by the stream format.
    localparam int POS_W    = 4;
    localparam int ACT_W    = 2;
    localparam int REWARD_W = 32;
    localparam int WVAL_W   = 32;
    localparam int DRAW_W   = 16;
    localparam int RESULT_W = 32;
    localparam int THRESH_W = 17;
    localparam int FRAC_W   = 16;
    localparam int GRID_W   = 5;

    // Width of y*grid_width + x before it is folded into the table.
    localparam int CELL_SUM_W = POS_W + GRID_W;

    // Stream data widths, padded to whole bytes, and stream user widths.
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID     = 2'd3;

    // Register values after reset.
    localparam logic [THRESH_W-1:0] EXPLORE_RST  = 17'd6554;
    localparam logic [FRAC_W-1:0]   LEARN_RST    = 16'd6554;
    localparam logic [FRAC_W-1:0]   DISCOUNT_RST = 16'd62259;
    localparam logic [GRID_W-1:0]   GRID_RST     = 5'd9;

    // Rounding constant for a Q0.16 multiply: one half of the kept result LSB.
    localparam int ROUND_HALF = 32768;

    typedef enum logic [1:0] {
        MODE_WRITE,
        MODE_CHOOSE,
        MODE_UPDATE,
        MODE_QUERY
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,
        ST_RD_CUR,
        ST_RD_NEXT,
        ST_BEST,
        ST_GMUL,
        ST_DELTA,
        ST_AMUL,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc_cell;
        logic rd_cur;
        logic rd_next;
        logic take_best;
        logic do_gmul;
        logic do_delta;
        logic do_amul;
        logic do_write;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  out_free;
    } status_t;

endpackage

FILE: design/qltu_ctrl.sv
module qltu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qltu_pkg::status_t  status,
    output qltu_pkg::cmd_t     cmd
);

    qltu_pkg::state_t state_reg;
    qltu_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qltu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one transaction through the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            qltu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = qltu_pkg::ST_CELL;
                end
            end
            qltu_pkg::ST_CELL:
            begin
                cmd.calc_cell = 1'b1;
                state_next    = qltu_pkg::ST_RD_CUR;
            end
            qltu_pkg::ST_RD_CUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = qltu_pkg::ST_RD_NEXT;
            end
            qltu_pkg::ST_RD_NEXT:
            begin
                // The current row arrives here; the next-cell row is fetched.
                cmd.rd_next = 1'b1;
                if (status.mode == qltu_pkg::MODE_UPDATE)
                begin
                    state_next = qltu_pkg::ST_BEST;
                end
                else if (status.mode == qltu_pkg::MODE_WRITE)
                begin
                    state_next = qltu_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = qltu_pkg::ST_RESULT;
                end
            end
            qltu_pkg::ST_BEST:
            begin
                cmd.take_best = 1'b1;
                state_next    = qltu_pkg::ST_GMUL;
            end
            qltu_pkg::ST_GMUL:
            begin
                cmd.do_gmul = 1'b1;
                state_next  = qltu_pkg::ST_DELTA;
            end
            qltu_pkg::ST_DELTA:
            begin
                cmd.do_delta = 1'b1;
                state_next   = qltu_pkg::ST_AMUL;
            end
            qltu_pkg::ST_AMUL:
            begin
                cmd.do_amul = 1'b1;
                state_next  = qltu_pkg::ST_WRITE;
            end
            qltu_pkg::ST_WRITE:
            begin
                cmd.do_write = 1'b1;
                state_next   = qltu_pkg::ST_RESULT;
            end
            qltu_pkg::ST_RESULT:
            begin
                // Hold until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = qltu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qltu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/qltu_datapath.sv
module qltu_datapath #(
    parameter int MAX_COLS   = qltu_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = qltu_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = qltu_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [qltu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [qltu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [qltu_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [qltu_pkg::IN_USER_W-1:0]    in_user,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qltu_pkg::OUT_DATA_W-1:0]   out_data,
    output logic [qltu_pkg::OUT_USER_W-1:0]   out_user,
    input  qltu_pkg::cmd_t                    cmd,
    output qltu_pkg::status_t                 status
);

    localparam int VB        = VALUE_BITS;
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int ROW_W     = 4 * VB;
    localparam int WIDE      = (VB > 32) ? VB : 32;
    localparam int DW        = WIDE + 2;
    localparam int GW        = VB + qltu_pkg::FRAC_W + 1;
    localparam int AW        = DW + qltu_pkg::FRAC_W + 1;
    localparam int SW        = DW + 2;
    localparam int SUM_W     = qltu_pkg::CELL_SUM_W;
    localparam int RED_W     = SUM_W + CELL_BITS + 1;
    localparam int FW        = qltu_pkg::FRAC_W;

    // Input field positions in tdata.
    localparam int POS_X_LSB  = 0;
    localparam int POS_Y_LSB  = POS_X_LSB + qltu_pkg::POS_W;
    localparam int ACT_LSB    = POS_Y_LSB + qltu_pkg::POS_W;
    localparam int REWARD_LSB = ACT_LSB + qltu_pkg::ACT_W;
    localparam int NEXT_X_LSB = REWARD_LSB + qltu_pkg::REWARD_W;
    localparam int NEXT_Y_LSB = NEXT_X_LSB + qltu_pkg::POS_W;
    localparam int WVAL_LSB   = NEXT_Y_LSB + qltu_pkg::POS_W;
    localparam int DRAW_LSB   = WVAL_LSB + qltu_pkg::WVAL_W;
    localparam int RACT_LSB   = DRAW_LSB + qltu_pkg::DRAW_W;

    // Fold y*grid_width + x into the table by restoring remainder steps.
    function automatic logic [CELL_BITS-1:0] fold_cell(input logic [SUM_W-1:0] s);
        logic [RED_W-1:0] v;
        v = RED_W'(s);
        for (int k = SUM_W - 1; k >= 0; k--)
        begin
            if (v >= (RED_W'(CELLS) << k))
            begin
                v = v - (RED_W'(CELLS) << k);
            end
        end
        return v[CELL_BITS-1:0];
    endfunction

    function automatic logic [VB-1:0] lane(input logic [ROW_W-1:0] row,
                                           input logic [1:0] idx);
        return row[idx*VB +: VB];
    endfunction

    // Argmax over the four actions of a row; ties go to the lower action.
    function automatic logic [1:0] argmax4(input logic [ROW_W-1:0] row);
        logic signed [VB-1:0] q0;
        logic signed [VB-1:0] q1;
        logic signed [VB-1:0] q2;
        logic signed [VB-1:0] q3;
        logic signed [VB-1:0] v01;
        logic signed [VB-1:0] v23;
        logic [1:0]           w01;
        logic [1:0]           w23;
        q0  = row[0*VB +: VB];
        q1  = row[1*VB +: VB];
        q2  = row[2*VB +: VB];
        q3  = row[3*VB +: VB];
        w01 = (q1 > q0) ? 2'd1 : 2'd0;
        v01 = (q1 > q0) ? q1 : q0;
        w23 = (q3 > q2) ? 2'd3 : 2'd2;
        v23 = (q3 > q2) ? q3 : q2;
        return (v23 > v01) ? w23 : w01;
    endfunction

    // Configuration registers.
    logic [qltu_pkg::THRESH_W-1:0] thresh_reg;
    logic [FW-1:0]                 alpha_reg;
    logic [FW-1:0]                 gamma_reg;
    logic [qltu_pkg::GRID_W-1:0]   grid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= qltu_pkg::EXPLORE_RST;
            alpha_reg  <= qltu_pkg::LEARN_RST;
            gamma_reg  <= qltu_pkg::DISCOUNT_RST;
            grid_reg   <= qltu_pkg::GRID_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qltu_pkg::CFG_EXPLORE:  thresh_reg <= cfg_data[qltu_pkg::THRESH_W-1:0];
                qltu_pkg::CFG_LEARN:    alpha_reg  <= cfg_data[FW-1:0];
                qltu_pkg::CFG_DISCOUNT: gamma_reg  <= cfg_data[FW-1:0];
                qltu_pkg::CFG_GRID:     grid_reg   <= cfg_data[qltu_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured transaction fields.
    qltu_pkg::mode_t                mode_reg;
    logic [qltu_pkg::POS_W-1:0]     pos_x_reg;
    logic [qltu_pkg::POS_W-1:0]     pos_y_reg;
    logic [qltu_pkg::ACT_W-1:0]     act_reg;
    logic signed [qltu_pkg::REWARD_W-1:0] reward_reg;
    logic [qltu_pkg::POS_W-1:0]     next_x_reg;
    logic [qltu_pkg::POS_W-1:0]     next_y_reg;
    logic signed [qltu_pkg::WVAL_W-1:0]   wval_reg;
    logic [qltu_pkg::DRAW_W-1:0]    draw_reg;
    logic [qltu_pkg::ACT_W-1:0]     ract_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= qltu_pkg::mode_t'(in_user[1:0]);
            pos_x_reg  <= in_data[POS_X_LSB +: qltu_pkg::POS_W];
            pos_y_reg  <= in_data[POS_Y_LSB +: qltu_pkg::POS_W];
            act_reg    <= in_data[ACT_LSB +: qltu_pkg::ACT_W];
            reward_reg <= in_data[REWARD_LSB +: qltu_pkg::REWARD_W];
            next_x_reg <= in_data[NEXT_X_LSB +: qltu_pkg::POS_W];
            next_y_reg <= in_data[NEXT_Y_LSB +: qltu_pkg::POS_W];
            wval_reg   <= in_data[WVAL_LSB +: qltu_pkg::WVAL_W];
            draw_reg   <= in_data[DRAW_LSB +: qltu_pkg::DRAW_W];
            ract_reg   <= in_data[RACT_LSB +: qltu_pkg::ACT_W];
        end
    end

    // Cell addresses of the current and the next cell.
    logic [CELL_BITS-1:0] cur_cell_reg;
    logic [CELL_BITS-1:0] nxt_cell_reg;
    logic [SUM_W-1:0]     cur_sum;
    logic [SUM_W-1:0]     nxt_sum;

    assign cur_sum = SUM_W'({{qltu_pkg::GRID_W{1'b0}}, pos_y_reg} * SUM_W'(grid_reg))
                   + SUM_W'(pos_x_reg);
    assign nxt_sum = SUM_W'({{qltu_pkg::GRID_W{1'b0}}, next_y_reg} * SUM_W'(grid_reg))
                   + SUM_W'(next_x_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_cell)
        begin
            cur_cell_reg <= fold_cell(cur_sum);
            nxt_cell_reg <= fold_cell(nxt_sum);
        end
    end

    // Q table: one row of four actions per cell, registered read.
    logic [ROW_W-1:0]     q_mem [CELLS];
    logic [ROW_W-1:0]     rd_row_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_wr;
    logic [CELL_BITS-1:0] rd_addr;

    assign rd_addr = cmd.rd_next ? nxt_cell_reg : cur_cell_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_cur || cmd.rd_next)
        begin
            rd_row_reg <= q_mem[rd_addr];
        end
        if (cmd.do_write)
        begin
            q_mem[cur_cell_reg] <= row_wr;
        end
    end

    // Working copy of the current row.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_next)
        begin
            row_reg <= rd_row_reg;
        end
        else if (cmd.do_write)
        begin
            row_reg <= row_wr;
        end
    end

    logic signed [VB-1:0] q_old;
    assign q_old = lane(row_reg, act_reg);

    // Best value of the next cell.
    logic signed [VB-1:0] best_next_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_best)
        begin
            best_next_reg <= lane(rd_row_reg, argmax4(rd_row_reg));
        end
    end

    // gamma * best, rounded half up.
    logic signed [GW-1:0] gmul;
    logic signed [GW-1:0] gmul_rnd;
    logic signed [VB:0]   gprod_reg;

    assign gmul     = best_next_reg * $signed({1'b0, gamma_reg});
    assign gmul_rnd = gmul + GW'(qltu_pkg::ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (cmd.do_gmul)
        begin
            gprod_reg <= gmul_rnd[GW-1:FW];
        end
    end

    // Temporal difference: gamma*best + reward - Q.
    logic signed [DW-1:0] delta_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.do_delta)
        begin
            delta_reg <= DW'(gprod_reg) + DW'(reward_reg) - DW'(q_old);
        end
    end

    // alpha * difference, rounded half up.
    logic signed [AW-1:0] amul;
    logic signed [AW-1:0] amul_rnd;
    logic signed [DW:0]   aprod_reg;

    assign amul     = delta_reg * $signed({1'b0, alpha_reg});
    assign amul_rnd = amul + AW'(qltu_pkg::ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (cmd.do_amul)
        begin
            aprod_reg <= amul_rnd[AW-1:FW];
        end
    end

    // Updated value, saturated to the stored width.
    logic signed [SW-1:0] upd_sum;
    logic [SW-VB:0]       upd_top;
    logic                 upd_ok;
    logic [VB-1:0]        upd_val;

    assign upd_sum = SW'(q_old) + SW'(aprod_reg);
    assign upd_top = upd_sum[SW-1:VB-1];
    assign upd_ok  = (&upd_top) || !(|upd_top);
    assign upd_val = upd_ok ? upd_sum[VB-1:0] :
                     (upd_sum[SW-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}});

    // Written value, saturated when the stored width is narrower.
    logic [VB-1:0] wr_val;
    logic          wr_clip;

    generate
        if (VB >= qltu_pkg::WVAL_W)
        begin : g_wval_wide
            assign wr_val  = VB'(wval_reg);
            assign wr_clip = 1'b0;
        end
        else
        begin : g_wval_narrow
            logic [qltu_pkg::WVAL_W-VB:0] wtop;
            logic                         wok;
            assign wtop    = wval_reg[qltu_pkg::WVAL_W-1:VB-1];
            assign wok     = (&wtop) || !(|wtop);
            assign wr_clip = !wok;
            assign wr_val  = wok ? wval_reg[VB-1:0] :
                             (wval_reg[qltu_pkg::WVAL_W-1] ? {1'b1, {(VB-1){1'b0}}}
                                                           : {1'b0, {(VB-1){1'b1}}});
        end
    endgenerate

    logic [VB-1:0] new_val;
    logic          new_clip;
    logic [VB-1:0] new_val_reg;
    logic          clip_reg;

    assign new_val  = (mode_reg == qltu_pkg::MODE_WRITE) ? wr_val : upd_val;
    assign new_clip = (mode_reg == qltu_pkg::MODE_WRITE) ? wr_clip : !upd_ok;

    // Row with the chosen action's entry replaced.
    always_comb
    begin
        row_wr = row_reg;
        row_wr[act_reg*VB +: VB] = new_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write)
        begin
            new_val_reg <= new_val;
            clip_reg    <= new_clip;
        end
    end

    // Result assembly from the current row.
    logic [1:0]                   cur_idx;
    logic [VB-1:0]                cur_best;
    logic                         explore;
    logic [qltu_pkg::ACT_W-1:0]   res_action;
    logic                         res_explored;
    logic                         res_clipped;
    logic [VB-1:0]                res_vb;
    logic [qltu_pkg::RESULT_W-1:0] res32;

    assign cur_idx  = argmax4(row_reg);
    assign cur_best = lane(row_reg, cur_idx);
    assign explore  = {1'b0, draw_reg} < thresh_reg;

    always_comb
    begin
        res_action   = cur_idx;
        res_explored = 1'b0;
        res_clipped  = 1'b0;
        res_vb       = cur_best;
        case (mode_reg)
            qltu_pkg::MODE_CHOOSE:
            begin
                res_explored = explore;
                if (explore)
                begin
                    res_action = ract_reg;
                end
            end
            qltu_pkg::MODE_UPDATE:
            begin
                res_vb      = new_val_reg;
                res_clipped = clip_reg;
            end
            qltu_pkg::MODE_WRITE:
            begin
                res_clipped = clip_reg;
            end
            default: ;
        endcase
    end

    generate
        if (VB >= qltu_pkg::RESULT_W)
        begin : g_res_trunc
            assign res32 = res_vb[qltu_pkg::RESULT_W-1:0];
        end
        else
        begin : g_res_ext
            assign res32 = {{(qltu_pkg::RESULT_W-VB){res_vb[VB-1]}}, res_vb};
        end
    endgenerate

    // Output register.
    logic                            out_valid_reg;
    logic [qltu_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [qltu_pkg::OUT_USER_W-1:0] out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= qltu_pkg::OUT_DATA_W'({res32, res_action});
            out_user_reg <= {res_clipped, res_explored};
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_user        = out_user_reg;
    assign status.mode     = mode_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

FILE: design/q_learning_table_update_core.sv
// Tabular Q-learning engine over a grid of up to MAX_COLS x MAX_ROWS cells with
// four actions each; Q values are signed Q16.16 held at VALUE_BITS bits. The
// tuser mode selects a table write (0), an epsilon-greedy action choice (1), a
// learning update Q += alpha*(gamma*maxQ' + reward - Q) with saturation (2),
// or a read-only query (3); every input transaction gives exactly one result
// transaction. One item is in work at a time: it passes the cell, read-current
// and read-next states, then in mode 2 the best, gamma multiply, difference,
// alpha multiply and write states, in mode 0 the write state, and last the
// result state, which loads the result register before the next transaction
// is accepted. A result that waits on the output holds the next item before
// its result register is loaded. The order is set by the single read port of
// the table, which returns one cell row per read, and in mode 2 by the two
// registered multiplies and the add and saturate that follow. The table has
// no reset; every entry that is read must have been written first with mode 0.
module q_learning_table_update_core #(
    parameter int MAX_COLS   = qltu_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = qltu_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = qltu_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [qltu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [qltu_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x[3:0], pos_y[7:4], act[9:8], reward[41:10], next_x[45:42],
    // next_y[49:46], write_value[81:50], random_draw[97:82],
    // rand_action[99:98], zero pad[103:100]
    input  logic [qltu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [qltu_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chosen_action[1:0], result_value[33:2], zero pad[39:34]
    output logic [qltu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // explored[0], saturated[1]
    output logic [qltu_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    qltu_pkg::cmd_t    cmd;
    qltu_pkg::status_t status;

    // Sequencer.
    qltu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, arithmetic and result register.
    qltu_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
